// ----- src/planar_to_packed_rgb_line_converter_unit_assert.svh -----
// assertion macros shared by the rgb line converter rtl
`ifndef PLANAR_TO_PACKED_RGB_LINE_CONVERTER_UNIT_ASSERT_SVH
`define PLANAR_TO_PACKED_RGB_LINE_CONVERTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define P2PRGB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define P2PRGB_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define P2PRGB_ASSERT(lbl, clk, rst_n, prop, msg)

`define P2PRGB_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ----- src/p2prgb_pkg.sv -----
// types, constants and helpers for the planar to packed rgb line converter
package p2prgb_pkg;

    localparam int MAX_WIDTH = 16384;
    localparam int BANK_SIZE = 3 * MAX_WIDTH;
    localparam int STORE_DEPTH = 2 * BANK_SIZE;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PX_W = $clog2(MAX_WIDTH);
    localparam int POS_W = $clog2(BANK_SIZE + 1);
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int LW_W = 15;
    localparam int CFG_ADDR_W = 3;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic MODE_PASS = 1'b0;
    localparam logic MODE_PACK = 1'b1;

    localparam logic REG_LINE_WIDTH = 1'b0;
    localparam logic REG_PACK_MODE = 1'b1;

    localparam logic [LW_W-1:0] LINE_WIDTH_RST = 15'd16384;

    localparam logic [1:0] CH_RED = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE = 2'd2;

    typedef struct packed {
        logic            pack_mode;
        logic [WW-1:0]   eff_w;
        logic [POS_W-1:0] line_len;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic       from_mem;
        logic [7:0] data;
        logic       last;
    } beat_t;

    function automatic logic [WW-1:0] eff_width(input logic [LW_W-1:0] lw);
        logic [WW-1:0] w;
        if (lw == '0)
            w = WW'(1);
        else if (32'(lw) > 32'(MAX_WIDTH))
            w = WW'(MAX_WIDTH);
        else
            w = WW'(lw);
        return w;
    endfunction

    function automatic logic [POS_W-1:0] line_length(input logic [WW-1:0] w);
        return POS_W'({w, 1'b0}) + POS_W'(w);
    endfunction

endpackage

// ----- src/p2prgb_if.sv -----
// stream interfaces for the converter input and output channels
interface p2prgb_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface p2prgb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       last_of_line;

    modport source (output valid, output packed_byte, output last_of_line, input ready);
    modport sink (input valid, input packed_byte, input last_of_line, output ready);
endinterface

// ----- src/planar_to_packed_rgb_line_converter_unit.sv -----
// Planar to packed RGB line converter, top level.
//
// in_ch carries one beat per scanner byte (operation data) or a drain tick
// (operation drain). out_ch carries packed bytes with last_of_line on the
// final byte of each line. The APB port sets line_width (offset 0) and
// pack_mode (offset 4); write them only while no beat is in flight.
// In pack mode each line is written into one bank of the line RAM while the
// previous line is read from the other bank in R,G,B pixel order, so output
// trails input by one line; drain ticks read out the final line.
// Passthrough mode forwards each data byte unchanged.
// Throughput is one beat per cycle while in_ch.ready is high, set by the
// one write and one read port of the line RAM, both used in the same
// cycle. Beats pass the ctrl beat register, then the output register.
// Reset clears all counters and the output buffer at once; the line RAM is
// not cleared and holds nothing valid until a line has been written.
// When out_ch stalls, a two-entry output buffer absorbs the RAM read in
// flight and in_ch.ready drops once both entries are spoken for.
`include "planar_to_packed_rgb_line_converter_unit_assert.svh"

module planar_to_packed_rgb_line_converter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [p2prgb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    p2prgb_in_if.sink                         in_ch,
    p2prgb_out_if.source                      out_ch
);

    logic [p2prgb_pkg::LW_W-1:0]  line_width_reg;
    logic                         pack_mode_reg;
    logic [p2prgb_pkg::WW-1:0]    eff_w_reg;
    logic [p2prgb_pkg::POS_W-1:0] line_len_reg;

    logic                          cfg_wr;
    logic [p2prgb_pkg::WW-1:0]     wr_eff_w;
    p2prgb_pkg::cfg_t              cfg;
    logic                          accept;
    logic                          room;
    logic                          skid_full;
    logic                          mem_we;
    logic [p2prgb_pkg::ADDR_W-1:0] mem_waddr;
    logic [7:0]                    mem_wdata;
    logic                          mem_re;
    logic [p2prgb_pkg::ADDR_W-1:0] mem_raddr;
    logic [7:0]                    mem_rdata;
    p2prgb_pkg::beat_t             beat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign wr_eff_w = p2prgb_pkg::eff_width(pwdata[p2prgb_pkg::LW_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= p2prgb_pkg::LINE_WIDTH_RST;
            pack_mode_reg <= p2prgb_pkg::MODE_PACK;
            eff_w_reg <= p2prgb_pkg::eff_width(p2prgb_pkg::LINE_WIDTH_RST);
            line_len_reg <= p2prgb_pkg::line_length(
                p2prgb_pkg::eff_width(p2prgb_pkg::LINE_WIDTH_RST));
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                p2prgb_pkg::REG_LINE_WIDTH:
                begin
                    line_width_reg <= pwdata[p2prgb_pkg::LW_W-1:0];
                    eff_w_reg <= wr_eff_w;
                    line_len_reg <= p2prgb_pkg::line_length(wr_eff_w);
                end
                p2prgb_pkg::REG_PACK_MODE:
                    pack_mode_reg <= pwdata[0];
                default:
                    pack_mode_reg <= pack_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            p2prgb_pkg::REG_LINE_WIDTH: prdata = 32'(line_width_reg);
            p2prgb_pkg::REG_PACK_MODE:  prdata = 32'(pack_mode_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.pack_mode = pack_mode_reg;
    assign cfg.eff_w = eff_w_reg;
    assign cfg.line_len = line_len_reg;

    assign in_ch.ready = room;
    assign accept = in_ch.valid && room;

    p2prgb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (in_ch.operation),
        .data_byte (in_ch.data_byte),
        .cfg       (cfg),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .beat      (beat)
    );

    p2prgb_line_ram #(
        .DEPTH  (p2prgb_pkg::STORE_DEPTH),
        .DATA_W (8),
        .ADDR_W (p2prgb_pkg::ADDR_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    p2prgb_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .mem_rdata (mem_rdata),
        .room      (room),
        .skid_full (skid_full),
        .out_ch    (out_ch)
    );

    // a beat leaving the ctrl stage must come from a beat accepted the cycle before
    `P2PRGB_ASSERT(a_beat_from_accept, clk, rst_n, beat.valid |-> $past(accept), "result beat without accepted input")

    // a full buffer that is not draining must never receive another beat
    `P2PRGB_NEVER(a_no_overflow, clk, rst_n, skid_full && !(out_ch.valid && out_ch.ready) && beat.valid, "output buffer overflow")

    // the skid entry is only occupied behind a valid output entry
    `P2PRGB_NEVER(a_skid_order, clk, rst_n, skid_full && !out_ch.valid, "skid entry valid with empty output register")

endmodule

// ----- src/p2prgb_line_ram.sv -----
// generic simple dual port ram with registered read data
module p2prgb_line_ram #(
    parameter int DEPTH = 1024,
    parameter int DATA_W = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ----- src/p2prgb_ctrl.sv -----
// line position counters, bank swap and line store address generation
module p2prgb_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         operation,
    input  logic [7:0]                   data_byte,
    input  p2prgb_pkg::cfg_t             cfg,
    output logic                         mem_we,
    output logic [p2prgb_pkg::ADDR_W-1:0] mem_waddr,
    output logic [7:0]                   mem_wdata,
    output logic                         mem_re,
    output logic [p2prgb_pkg::ADDR_W-1:0] mem_raddr,
    output p2prgb_pkg::beat_t            beat
);

    logic [p2prgb_pkg::POS_W-1:0] write_pos_reg, write_pos_next;
    logic                         write_bank_reg, write_bank_next;
    logic [p2prgb_pkg::POS_W-1:0] read_pos_reg, read_pos_next;
    logic                         read_active_reg, read_active_next;
    logic [1:0]                   read_ch_reg, read_ch_next;
    logic [p2prgb_pkg::PX_W-1:0]  read_px_reg, read_px_next;
    p2prgb_pkg::beat_t            beat_reg, beat_next;

    logic                         packing;
    logic                         emit;
    logic                         store;
    logic [p2prgb_pkg::POS_W-1:0] read_pos_inc;
    logic [p2prgb_pkg::POS_W-1:0] write_pos_inc;
    logic [p2prgb_pkg::POS_W-1:0] plane_off;

    assign packing = accept && (cfg.pack_mode == p2prgb_pkg::MODE_PACK);
    assign emit = packing && read_active_reg && (read_pos_reg < cfg.line_len);
    assign store = packing && (operation == p2prgb_pkg::OP_DATA);
    assign read_pos_inc = read_pos_reg + 1'b1;
    assign write_pos_inc = write_pos_reg + 1'b1;

    always_comb
    begin
        case (read_ch_reg)
            p2prgb_pkg::CH_GREEN: plane_off = p2prgb_pkg::POS_W'(cfg.eff_w);
            p2prgb_pkg::CH_BLUE:  plane_off = p2prgb_pkg::POS_W'({cfg.eff_w, 1'b0});
            default:              plane_off = '0;
        endcase
    end

    // read bank is always the one not being written, so no same-entry overlap
    assign mem_re = emit;
    assign mem_raddr = (write_bank_reg ? '0 : p2prgb_pkg::ADDR_W'(p2prgb_pkg::BANK_SIZE))
                     + p2prgb_pkg::ADDR_W'(plane_off)
                     + p2prgb_pkg::ADDR_W'(read_px_reg);

    assign mem_we = store;
    assign mem_wdata = data_byte;
    assign mem_waddr = (write_bank_reg ? p2prgb_pkg::ADDR_W'(p2prgb_pkg::BANK_SIZE) : '0)
                     + p2prgb_pkg::ADDR_W'(write_pos_reg);

    always_comb
    begin
        write_pos_next = write_pos_reg;
        write_bank_next = write_bank_reg;
        read_pos_next = read_pos_reg;
        read_active_next = read_active_reg;
        read_ch_next = read_ch_reg;
        read_px_next = read_px_reg;
        beat_next = '0;

        if (accept && (cfg.pack_mode == p2prgb_pkg::MODE_PASS))
        begin
            beat_next.valid = (operation == p2prgb_pkg::OP_DATA);
            beat_next.data = data_byte;
        end

        if (packing && read_active_reg && !emit)
            read_active_next = 1'b0;

        if (emit)
        begin
            beat_next.valid = 1'b1;
            beat_next.from_mem = 1'b1;
            beat_next.last = (read_pos_inc >= cfg.line_len);
            read_pos_next = read_pos_inc;
            if (read_pos_inc >= cfg.line_len)
                read_active_next = 1'b0;
            if (read_ch_reg == p2prgb_pkg::CH_BLUE)
            begin
                read_ch_next = p2prgb_pkg::CH_RED;
                read_px_next = read_px_reg + 1'b1;
            end
            else
            begin
                read_ch_next = read_ch_reg + 1'b1;
            end
        end

        if (store)
        begin
            write_pos_next = write_pos_inc;
            // line complete: swap banks and restart the readout
            if (write_pos_inc >= cfg.line_len)
            begin
                write_bank_next = ~write_bank_reg;
                write_pos_next = '0;
                read_pos_next = '0;
                read_ch_next = p2prgb_pkg::CH_RED;
                read_px_next = '0;
                read_active_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg <= '0;
            write_bank_reg <= 1'b0;
            read_pos_reg <= '0;
            read_active_reg <= 1'b0;
            read_ch_reg <= p2prgb_pkg::CH_RED;
            read_px_reg <= '0;
            beat_reg <= '0;
        end
        else
        begin
            write_pos_reg <= write_pos_next;
            write_bank_reg <= write_bank_next;
            read_pos_reg <= read_pos_next;
            read_active_reg <= read_active_next;
            read_ch_reg <= read_ch_next;
            read_px_reg <= read_px_next;
            beat_reg <= beat_next;
        end
    end

    assign beat = beat_reg;

endmodule

// ----- src/p2prgb_out_buf.sv -----
// two-entry output buffer that catches ram read data under back-pressure
module p2prgb_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  p2prgb_pkg::beat_t beat,
    input  logic [7:0]        mem_rdata,
    output logic              room,
    output logic              skid_full,
    p2prgb_out_if.source      out_ch
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;
    logic       out_last_reg, out_last_next;
    logic       skid_valid_reg, skid_valid_next;
    logic [7:0] skid_data_reg, skid_data_next;
    logic       skid_last_reg, skid_last_next;

    logic       pop;
    logic [7:0] beat_data;
    logic [1:0] fill;

    assign pop = out_valid_reg && out_ch.ready;
    assign beat_data = beat.from_mem ? mem_rdata : beat.data;

    // one beat may still come out of the ram, so leave a slot for it
    assign fill = 2'(out_valid_reg) + 2'(skid_valid_reg) + 2'(beat.valid) - 2'(pop);
    assign room = (fill <= 2'd1);
    assign skid_full = skid_valid_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next = skid_data_reg;
        skid_last_next = skid_last_reg;

        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next = skid_data_reg;
                out_last_next = skid_last_reg;
                skid_valid_next = beat.valid;
                skid_data_next = beat_data;
                skid_last_next = beat.last;
            end
            else
            begin
                out_valid_next = beat.valid;
                out_data_next = beat_data;
                out_last_next = beat.last;
            end
        end
        else if (beat.valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next = beat_data;
            skid_last_next = beat.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        skid_data_reg <= skid_data_next;
        skid_last_reg <= skid_last_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.packed_byte = out_data_reg;
    assign out_ch.last_of_line = out_last_reg;

endmodule
